>>> src/robi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package robi_pkg;

  // coordinate fraction bits and slab scaling
  localparam int F          = 16;
  localparam int SLAB_ALIGN = 23;
  localparam int HSH        = 2 * F - SLAB_ALIGN;

  // internal widths
  localparam int NW = 84;   // slab numerator, signed
  localparam int DW = 68;   // slab denominator / local position, signed
  localparam int AW = 69;   // half size times |det|, unsigned
  localparam int QW = 32;   // quotient bits

  // pipeline depths
  localparam int XF_LAT  = 5;
  localparam int DIV_LAT = QW + 2;
  localparam int HIT_LAT = 3;
  localparam int TOT_LAT = XF_LAT + DIV_LAT + HIT_LAT;

  localparam logic signed [31:0] T_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] T_MAX = 32'sh7fff_ffff;

  typedef enum logic [2:0] {
    REG_ROW0   = 3'd0,
    REG_ROW1   = 3'd1,
    REG_ROW2   = 3'd2,
    REG_TX     = 3'd3,
    REG_TY     = 3'd4,
    REG_TZ     = 3'd5,
    REG_EXTENT = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [2:0][31:0] org;
    logic [2:0][31:0] hd;
  } ray_t;

  typedef struct packed {
    logic [NW-1:0] nmin;
    logic [NW-1:0] nmax;
    logic [DW-1:0] den;
  } slab_t;

  typedef struct packed {
    logic [2:0] dz;
    logic [2:0] bad;
    logic       detz;
    ray_t       ray;
  } side_t;

endpackage
`default_nettype wire

>>> src/robi_xform.sv
`timescale 1ns / 1ps
`default_nettype none
module robi_xform import robi_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [2:0][47:0] rows,
  input  logic [2:0][31:0] trans,
  input  logic [59:0]      ext,
  input  ray_t             ray_i,
  output slab_t [2:0]      slab_o,
  output ray_t             ray_o,
  output logic             detz_o
);

  logic signed [15:0] m [3][3];
  logic signed [32:0] cof_r [3][3];
  logic signed [50:0] det_r;
  logic [48:0]        adet;
  logic [44:0]        hpl_r [3];
  logic [43:0]        hph_r [3];
  logic [AW-1:0]      ah_r [3];

  logic signed [32:0] v1_r [3];
  ray_t               ray1_r, ray2_r, ray3_r, ray4_r, ray5_r;
  logic signed [48:0] pvh_r [3][3];
  logic signed [50:0] pvl_r [3][3];
  logic signed [47:0] pdh_r [3][3];
  logic signed [49:0] pdl_r [3][3];
  logic signed [DW-1:0] psum [3], dsum [3];
  logic signed [DW-1:0] p3_r [3], d3_r [3], p4_r [3], d4_r [3];
  logic               detz4_r, detz5_r;
  slab_t [2:0]        slab5_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m[i][j] = $signed(rows[i][16*j +: 16]);
      end
    end
  end

  // box-derived terms follow the registers after a write, through the cofactor, determinant and half-size registers
  for (genvar j = 0; j < 3; j++) begin : g_cj
    for (genvar i = 0; i < 3; i++) begin : g_ci
      localparam int J1 = (j + 1) % 3;
      localparam int J2 = (j + 2) % 3;
      localparam int I1 = (i + 1) % 3;
      localparam int I2 = (i + 2) % 3;
      always_ff @(posedge clk) begin
        cof_r[j][i] <= m[J1][I1] * m[J2][I2] - m[J1][I2] * m[J2][I1];
      end
    end
  end

  always_ff @(posedge clk) begin
    det_r <= m[0][0] * cof_r[0][0] + m[0][1] * cof_r[0][1] + m[0][2] * cof_r[0][2];
  end

  assign adet = det_r[50] ? 49'(-det_r) : 49'(det_r);

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      hpl_r[k] <= ext[20*k +: 20] * adet[24:0];
      hph_r[k] <= ext[20*k +: 20] * adet[48:25];
      ah_r[k]  <= (AW'(hph_r[k]) << 25) + AW'(hpl_r[k]);
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      psum[j] = '0;
      dsum[j] = '0;
      for (int i = 0; i < 3; i++) begin
        psum[j] = psum[j] + (DW'(pvh_r[j][i]) <<< 17) + DW'(pvl_r[j][i]);
        dsum[j] = dsum[j] + (DW'(pdh_r[j][i]) <<< 17) + DW'(pdl_r[j][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // S1: offset from box origin
      for (int i = 0; i < 3; i++) begin
        v1_r[i] <= $signed(ray_i.org[i]) - $signed(trans[i]);
      end
      ray1_r <= ray_i;
      // S2: partial products against the cofactors
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          pvh_r[j][i] <= v1_r[i] * $signed(cof_r[j][i][32:17]);
          pvl_r[j][i] <= v1_r[i] * $signed({1'b0, cof_r[j][i][16:0]});
          pdh_r[j][i] <= $signed(ray1_r.hd[i]) * $signed(cof_r[j][i][32:17]);
          pdl_r[j][i] <= $signed(ray1_r.hd[i]) * $signed({1'b0, cof_r[j][i][16:0]});
        end
      end
      ray2_r <= ray1_r;
      // S3: sums
      for (int j = 0; j < 3; j++) begin
        p3_r[j] <= psum[j];
        d3_r[j] <= dsum[j];
      end
      ray3_r <= ray2_r;
      // S4: fold the determinant sign
      for (int j = 0; j < 3; j++) begin
        p4_r[j] <= det_r[50] ? -p3_r[j] : p3_r[j];
        d4_r[j] <= det_r[50] ? -d3_r[j] : d3_r[j];
      end
      detz4_r <= (det_r == '0);
      ray4_r  <= ray3_r;
      // S5: slab numerators
      for (int j = 0; j < 3; j++) begin
        slab5_r[j].nmax <= (NW'(ah_r[j]) << HSH) - (NW'(p4_r[j]) <<< F);
        slab5_r[j].nmin <= -(NW'(ah_r[j]) << HSH) - (NW'(p4_r[j]) <<< F);
        slab5_r[j].den  <= d4_r[j];
      end
      detz5_r <= detz4_r;
      ray5_r  <= ray4_r;
    end
  end

  assign slab_o = slab5_r;
  assign ray_o  = ray5_r;
  assign detz_o = detz5_r;

endmodule
`default_nettype wire

>>> src/robi_div.sv
`timescale 1ns / 1ps
`default_nettype none
module robi_div import robi_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [31:0]   quo
);

  localparam int CW = DW + QW;

  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] dm_r  [QW];
  logic [QW-1:0] q_r   [QW+1];
  logic          neg_r [QW+1];
  logic          ovf_r [QW+1];
  logic [NW-1:0] nm;
  logic [DW-1:0] dm;
  logic [QW-1:0] qf;
  logic [31:0]   quo_r;

  assign nm = num[NW-1] ? -num : num;
  assign dm = den[DW-1] ? -den : den;

  // prep: magnitudes, sign, quotient overflow
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= nm;
      dm_r[0]  <= dm;
      q_r[0]   <= '0;
      neg_r[0] <= num[NW-1] ^ den[DW-1];
      ovf_r[0] <= CW'(nm) >= (CW'(dm) << QW);
    end
  end

  // one restoring step per stage, MSB first
  for (genvar s = 0; s < QW; s++) begin : g_st
    localparam int K = QW - 1 - s;
    logic [CW-1:0] trial;
    logic          take;
    assign trial = CW'(dm_r[s]) << K;
    assign take  = CW'(rem_r[s]) >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s+1]   <= q_r[s] | (QW'(take) << K);
        neg_r[s+1] <= neg_r[s];
        ovf_r[s+1] <= ovf_r[s];
      end
    end
    if (s < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s+1] <= take ? NW'(CW'(rem_r[s]) - trial) : rem_r[s];
          dm_r[s+1]  <= dm_r[s];
        end
      end
    end
  end

  assign qf = q_r[QW];

  // signed result, saturated
  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_r[QW]) begin
        quo_r <= (ovf_r[QW] || (qf[QW-1] && (qf[QW-2:0] != '0))) ? T_MIN : 32'(-qf);
      end else begin
        quo_r <= (ovf_r[QW] || qf[QW-1]) ? T_MAX : 32'(qf);
      end
    end
  end

  assign quo = quo_r;

endmodule
`default_nettype wire

>>> src/robi_hit.sv
`timescale 1ns / 1ps
`default_nettype none
module robi_hit import robi_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [2:0][31:0] t1,
  input  logic [2:0][31:0] t2,
  input  side_t            side,
  output logic             hit,
  output logic [31:0]      entry,
  output logic [2:0][31:0] pnt
);

  logic signed [31:0] lo, hi, a, b;
  logic               miss;
  logic signed [31:0] lo1_r, lo2_r;
  logic               hit1_r, hit2_r, hit3_r;
  ray_t               ray1_r;
  logic [2:0][31:0]   org2_r;
  logic signed [63:0] prod_r [3];
  logic signed [64:0] rnd [3], sh [3];
  logic signed [65:0] sum [3];
  logic [2:0][31:0]   pnt3_r;
  logic [31:0]        ent3_r;

  // clip entry/exit over the bounded axes
  always_comb begin
    lo   = T_MIN;
    hi   = T_MAX;
    miss = side.detz | (|side.bad);
    for (int j = 0; j < 3; j++) begin
      a = $signed(t1[j]);
      b = $signed(t2[j]);
      if (a > b) begin
        a = $signed(t2[j]);
        b = $signed(t1[j]);
      end
      if (!side.dz[j]) begin
        if (a > lo) lo = a;
        if (b < hi) hi = b;
      end
    end
    if (lo >= hi) miss = 1'b1;
  end

  // entry point: round half up, then saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = 65'(prod_r[i]) + (65'sd1 <<< (F - 1));
      sh[i]  = rnd[i] >>> F;
      sum[i] = 66'($signed(org2_r[i])) + 66'(sh[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo1_r  <= lo;
      hit1_r <= !miss;
      ray1_r <= side.ray;
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= lo1_r * $signed(ray1_r.hd[i]);
      end
      lo2_r  <= lo1_r;
      hit2_r <= hit1_r;
      org2_r <= ray1_r.org;
      hit3_r <= hit2_r;
      ent3_r <= hit2_r ? lo2_r : '0;
      for (int i = 0; i < 3; i++) begin
        if (!hit2_r) pnt3_r[i] <= '0;
        else if (sum[i] > 66'(T_MAX)) pnt3_r[i] <= T_MAX;
        else if (sum[i] < 66'(T_MIN)) pnt3_r[i] <= T_MIN;
        else pnt3_r[i] <= 32'(sum[i]);
      end
    end
  end

  assign hit   = hit3_r;
  assign entry = ent3_r;
  assign pnt   = pnt3_r;

endmodule
`default_nettype wire

>>> src/ray_oriented_box_intersect_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Ray against oriented box (slab test), fully pipelined: one item per cycle. The depth is set
// by the six slab dividers, each a 32-stage restoring divider with a prep and a saturate
// stage, between a 5-stage frame transform (cofactor products of the box matrix) and a
// 3-stage clip and hit-point multiply. A stall on the result side freezes the whole pipe;
// in_ready is low only while a result waits. Box registers (APB, 64-bit data, register i
// at byte 8*i) feed cofactor, determinant and half-size terms, registered in that order
// after a write. A miss or a singular matrix gives an all-zero result.
module ray_oriented_box_intersect_core import robi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // item in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_origin_x,
  input  logic [31:0] in_origin_y,
  input  logic [31:0] in_origin_z,
  input  logic [31:0] in_heading_x,
  input  logic [31:0] in_heading_y,
  input  logic [31:0] in_heading_z,
  // result out
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [31:0] out_entry_distance,
  output logic [31:0] out_hit_x,
  output logic [31:0] out_hit_y,
  output logic [31:0] out_hit_z,
  // config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [2:0][47:0] row_r;
  logic [2:0][31:0] trans_r;
  logic [59:0]      ext_r;
  logic             en;
  logic [TOT_LAT-1:0] vld_r;
  ray_t             ray_in, ray5;
  slab_t [2:0]      slab5;
  logic             detz5;
  side_t            side_in;
  side_t            side_r [DIV_LAT];
  logic [2:0][31:0] t1, t2;
  logic [2:0][31:0] pnt;
  reg_idx_t         ridx;

  // ---- config port ----
  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      trans_r <= '0;
      ext_r   <= '0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_ROW0:   row_r[0]   <= pwdata[47:0];
        REG_ROW1:   row_r[1]   <= pwdata[47:0];
        REG_ROW2:   row_r[2]   <= pwdata[47:0];
        REG_TX:     trans_r[0] <= pwdata[31:0];
        REG_TY:     trans_r[1] <= pwdata[31:0];
        REG_TZ:     trans_r[2] <= pwdata[31:0];
        REG_EXTENT: ext_r      <= pwdata[59:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_ROW0:   prdata = {16'b0, row_r[0]};
      REG_ROW1:   prdata = {16'b0, row_r[1]};
      REG_ROW2:   prdata = {16'b0, row_r[2]};
      REG_TX:     prdata = {32'b0, trans_r[0]};
      REG_TY:     prdata = {32'b0, trans_r[1]};
      REG_TZ:     prdata = {32'b0, trans_r[2]};
      REG_EXTENT: prdata = {4'b0, ext_r};
      default:    prdata = '0;
    endcase
  end

  // ---- pipeline control: global advance, valid bit per stage ----
  assign en       = !vld_r[TOT_LAT-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOT_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[TOT_LAT-1];

  // ---- frame transform ----
  assign ray_in.org = {in_origin_z, in_origin_y, in_origin_x};
  assign ray_in.hd  = {in_heading_z, in_heading_y, in_heading_x};

  robi_xform u_xform (
    .clk    (clk),
    .en     (en),
    .rows   (row_r),
    .trans  (trans_r),
    .ext    (ext_r),
    .ray_i  (ray_in),
    .slab_o (slab5),
    .ray_o  (ray5),
    .detz_o (detz5)
  );

  // flat-axis containment check, carried beside the dividers
  always_comb begin
    side_in.detz = detz5;
    side_in.ray  = ray5;
    for (int j = 0; j < 3; j++) begin
      side_in.dz[j]  = (slab5[j].den == '0);
      side_in.bad[j] = side_in.dz[j] &&
                       ($signed(slab5[j].nmax) < 0 || $signed(slab5[j].nmin) > 0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int k = 1; k < DIV_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // ---- slab dividers: near and far plane per axis ----
  for (genvar j = 0; j < 3; j++) begin : g_ax
    robi_div u_div_near (
      .clk (clk),
      .en  (en),
      .num (slab5[j].nmin),
      .den (slab5[j].den),
      .quo (t1[j])
    );
    robi_div u_div_far (
      .clk (clk),
      .en  (en),
      .num (slab5[j].nmax),
      .den (slab5[j].den),
      .quo (t2[j])
    );
  end

  // ---- clip and entry point ----
  robi_hit u_hit (
    .clk   (clk),
    .en    (en),
    .t1    (t1),
    .t2    (t2),
    .side  (side_r[DIV_LAT-1]),
    .hit   (out_hit),
    .entry (out_entry_distance),
    .pnt   (pnt)
  );

  assign out_hit_x = pnt[0];
  assign out_hit_y = pnt[1];
  assign out_hit_z = pnt[2];

endmodule
`default_nettype wire

>>> tb/ray_oriented_box_intersect_core_tb.sv
`timescale 1ns / 1ps
// Oriented-box slab test bench: rays go in through a valid/ready channel, box setup goes
// through the APB port between phases, and every result is checked against a typed answer
// or a bit-exact predictor (exact rationals in wide signed vectors, one rounding per plane).
module ray_oriented_box_intersect_core_tb;
  import robi_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int NUM_PHASES  = 12;
  localparam int NUM_DIRECT  = 16;

  typedef logic signed [159:0] wide_t;

  typedef struct packed {
    logic [31:0] ox, oy, oz;
    logic [31:0] hx, hy, hz;
  } probe_ray_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] t_entry;
    logic [31:0] px, py, pz;
  } box_hit_t;

  // one row of the hand-written list; typed rows carry their answer, the rest use the model
  typedef struct packed {
    logic       ph;
    logic       typed;
    probe_ray_t ray;
    box_hit_t   want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_origin_x, in_origin_y, in_origin_z;
  logic [31:0] in_heading_x, in_heading_y, in_heading_z;
  logic        out_valid;
  logic        out_ready;
  logic        out_hit;
  logic [31:0] out_entry_distance, out_hit_x, out_hit_y, out_hit_z;
  logic        psel, penable, pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  ray_oriented_box_intersect_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_origin_x       (in_origin_x),
    .in_origin_y       (in_origin_y),
    .in_origin_z       (in_origin_z),
    .in_heading_x      (in_heading_x),
    .in_heading_y      (in_heading_y),
    .in_heading_z      (in_heading_z),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_entry_distance(out_entry_distance),
    .out_hit_x         (out_hit_x),
    .out_hit_y         (out_hit_y),
    .out_hit_z         (out_hit_z),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // shadow copy of the box registers
  logic [47:0] box_row [3];
  logic [31:0] box_shift [3];
  logic [59:0] box_size;

  box_hit_t   hit_queue[$];
  int         fail_count;
  int         items_sent;
  int         results_seen;
  int         hits_seen;
  int         cycle_count;
  bit         tail_phase;    // no idling on either side
  bit         calm_out;      // stretch with out_ready held high
  int         stall_left;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               hit_queue.size());
      $display("FAIL");
      $finish;
    end
  end

  // |n|/|d| truncated, sign applied, clamped to 32 bits
  function automatic longint clamp_quot(wide_t n, wide_t dn);
    bit    neg;
    wide_t q;
    neg = (n < 0) != (dn < 0);
    if (n < 0) n = -n;
    if (dn < 0) dn = -dn;
    q = n / dn;
    if (neg) return (q > 64'sh8000_0000) ? -64'sh8000_0000 : -longint'(q);
    return (q > 64'sh7fff_ffff) ? 64'sh7fff_ffff : longint'(q);
  endfunction

  function automatic logic [31:0] sat_word(longint x);
    if (x > 64'sh7fff_ffff) return T_MAX;
    if (x < -64'sh8000_0000) return T_MIN;
    return x[31:0];
  endfunction

  // ray into the box frame through the cofactor inverse, then three slabs
  function automatic box_hit_t slab_predict(probe_ray_t r);
    box_hit_t res;
    longint   mtx [3][3];
    longint   cof [3][3];
    longint   org [3];
    longint   hdg [3];
    longint   rel [3];
    longint   half [3];
    longint   det, adet, lo, hi, t1, t2, tmp, prod;
    wide_t    p, d, hterm, pterm, nmax, nmin, den;
    int       i, j;
    res = '0;
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++)
        mtx[i][j] = longint'($signed(box_row[i][16*j +: 16]));
    org[0] = longint'($signed(r.ox));
    org[1] = longint'($signed(r.oy));
    org[2] = longint'($signed(r.oz));
    hdg[0] = longint'($signed(r.hx));
    hdg[1] = longint'($signed(r.hy));
    hdg[2] = longint'($signed(r.hz));
    for (i = 0; i < 3; i++) begin
      rel[i] = org[i] - longint'($signed(box_shift[i]));
      half[i] = longint'({44'd0, box_size[20*i +: 20]});
    end
    for (j = 0; j < 3; j++)
      for (i = 0; i < 3; i++)
        cof[j][i] = mtx[(j+1)%3][(i+1)%3] * mtx[(j+2)%3][(i+2)%3]
                  - mtx[(j+1)%3][(i+2)%3] * mtx[(j+2)%3][(i+1)%3];
    det = mtx[0][0] * cof[0][0] + mtx[0][1] * cof[0][1] + mtx[0][2] * cof[0][2];
    if (det == 0) return res;   // singular box
    adet = (det < 0) ? -det : det;
    lo = -64'sh8000_0000;
    hi = 64'sh7fff_ffff;
    for (j = 0; j < 3; j++) begin
      p = '0;
      d = '0;
      for (i = 0; i < 3; i++) begin
        p = p + wide_t'(rel[i]) * wide_t'(cof[j][i]);
        d = d + wide_t'(hdg[i]) * wide_t'(cof[j][i]);
      end
      if (det < 0) begin
        p = -p;
        d = -d;
      end
      hterm = (wide_t'(half[j]) * wide_t'(adet)) <<< F;
      pterm = p <<< SLAB_ALIGN;
      nmax = hterm - pterm;
      nmin = -hterm - pterm;
      if (d == 0) begin
        // parallel axis: origin must lie inside the slab
        if (nmax < 0 || nmin > 0) return res;
      end else begin
        den = d <<< SLAB_ALIGN;
        t1 = clamp_quot(nmin <<< F, den);
        t2 = clamp_quot(nmax <<< F, den);
        if (t1 > t2) begin
          tmp = t1;
          t1 = t2;
          t2 = tmp;
        end
        if (t1 > lo) lo = t1;
        if (t2 < hi) hi = t2;
        if (lo >= hi) return res;
      end
    end
    res.hit = 1'b1;
    res.t_entry = lo[31:0];
    prod = lo * hdg[0] + (64'sd1 <<< (F - 1));
    res.px = sat_word(org[0] + (prod >>> F));
    prod = lo * hdg[1] + (64'sd1 <<< (F - 1));
    res.py = sat_word(org[1] + (prod >>> F));
    prod = lo * hdg[2] + (64'sd1 <<< (F - 1));
    res.pz = sat_word(org[2] + (prod >>> F));
    return res;
  endfunction

  // APB write: setup then access, register taken at the access edge
  task automatic reg_write(reg_idx_t idx, logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ROW0:   box_row[0]   = val[47:0];
      REG_ROW1:   box_row[1]   = val[47:0];
      REG_ROW2:   box_row[2]   = val[47:0];
      REG_TX:     box_shift[0] = val[31:0];
      REG_TY:     box_shift[1] = val[31:0];
      REG_TZ:     box_shift[2] = val[31:0];
      REG_EXTENT: box_size     = val[59:0];
      default: ;
    endcase
  endtask

  task automatic load_box(logic [47:0] r0, logic [47:0] r1, logic [47:0] r2,
                          logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                          logic [59:0] ext);
    reg_write(REG_ROW0, {16'd0, r0});
    reg_write(REG_ROW1, {16'd0, r1});
    reg_write(REG_ROW2, {16'd0, r2});
    reg_write(REG_TX, {32'd0, tx});
    reg_write(REG_TY, {32'd0, ty});
    reg_write(REG_TZ, {32'd0, tz});
    reg_write(REG_EXTENT, {4'd0, ext});
    // wait for the derived cofactor, determinant and half-size terms to settle after the last write
    repeat (6) @(posedge clk);
  endtask

  // holds the item until taken; returns at the accepting edge with valid still high
  task automatic send_ray(probe_ray_t r, bit typed, box_hit_t want);
    bit       taken;
    box_hit_t exp_r;
    in_valid     <= 1'b1;
    in_origin_x  <= r.ox;
    in_origin_y  <= r.oy;
    in_origin_z  <= r.oz;
    in_heading_x <= r.hx;
    in_heading_y <= r.hy;
    in_heading_z <= r.hz;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      if (taken) begin
        exp_r = typed ? want : slab_predict(r);
        hit_queue = {hit_queue, exp_r};
      end
      @(posedge clk);
    end
    items_sent++;
  endtask

  task automatic maybe_gap();
    int n;
    if (tail_phase || $urandom_range(0, 7) != 0) return;
    n = $urandom_range(1, 10);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (TOT_LAT + 4) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_diag();
    logic [15:0] v;
    v = 16'($urandom_range(16'h1000, 16'h7fff));
    return $urandom_range(0, 1) ? v : -v;
  endfunction

  function automatic logic [15:0] rand_off();
    return 16'($urandom_range(0, 16'h1000)) - 16'h0800;
  endfunction

  function automatic logic [31:0] near(logic [31:0] base, int span);
    return base + 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  task automatic load_random_box();
    logic [47:0] r [3];
    logic [31:0] t [3];
    logic [59:0] ext;
    int          i;
    for (i = 0; i < 3; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        r[i] = {16'($urandom), 32'($urandom)};
      end else begin
        r[i] = {rand_off(), rand_off(), rand_off()};
        r[i][16*i +: 16] = rand_diag();
      end
      t[i] = $urandom_range(0, 5) == 0 ? 32'($urandom) : near(32'd0, 32'h0100_0000);
      ext[20*i +: 20] = $urandom_range(0, 5) == 0 ? 20'($urandom)
                                                  : 20'($urandom_range(16'h0800, 18'h3ffff));
    end
    load_box(r[0], r[1], r[2], t[0], t[1], t[2], ext);
  endtask

  // mostly rays aimed near the box center, some parallel to an axis, some pure noise
  function automatic probe_ray_t rand_ray();
    probe_ray_t r;
    int         mode;
    mode = $urandom_range(0, 9);
    if (mode >= 8) begin
      r = {32'($urandom), 32'($urandom), 32'($urandom),
           32'($urandom), 32'($urandom), 32'($urandom)};
    end else begin
      r.ox = near(box_shift[0], 32'h0040_0000);
      r.oy = near(box_shift[1], 32'h0040_0000);
      r.oz = near(box_shift[2], 32'h0040_0000);
      r.hx = near(32'd0, 32'h0004_0000);
      r.hy = near(32'd0, 32'h0004_0000);
      r.hz = near(32'd0, 32'h0004_0000);
      if (mode == 7 || $urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 2))
          0: r.hx = '0;
          1: r.hy = '0;
          default: r.hz = '0;
        endcase
      end
    end
    return r;
  endfunction

  // out_ready: random stall bursts, calm stretches, none at the tail
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) calm_out = !calm_out;
    if (tail_phase || calm_out) begin
      out_ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // results are stable between edges, so check at the falling edge
  always @(negedge clk) begin
    box_hit_t exp_hit;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (hit_queue.size() == 0) begin
        $error("result with nothing pending");
        fail_count++;
      end else begin
        exp_hit = hit_queue.pop_front();
        if (exp_hit.hit) hits_seen++;
        if (out_hit !== exp_hit.hit) begin
          $error("hit: expected %0h got %0h", exp_hit.hit, out_hit);
          fail_count++;
        end
        if (out_entry_distance !== exp_hit.t_entry) begin
          $error("entry_distance: expected %08h got %08h", exp_hit.t_entry,
                 out_entry_distance);
          fail_count++;
        end
        if (out_hit_x !== exp_hit.px) begin
          $error("hit_x: expected %08h got %08h", exp_hit.px, out_hit_x);
          fail_count++;
        end
        if (out_hit_y !== exp_hit.py) begin
          $error("hit_y: expected %08h got %08h", exp_hit.py, out_hit_y);
          fail_count++;
        end
        if (out_hit_z !== exp_hit.pz) begin
          $error("hit_z: expected %08h got %08h", exp_hit.pz, out_hit_z);
          fail_count++;
        end
      end
    end
  end

  dir_row_t dir_rows [NUM_DIRECT];

  initial begin
    box_hit_t no_hit;
    int       ph, k, n, wait_cycles;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_origin_x = '0;
    in_origin_y = '0;
    in_origin_z = '0;
    in_heading_x = '0;
    in_heading_y = '0;
    in_heading_z = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_count = 0;
    items_sent = 0;
    results_seen = 0;
    hits_seen = 0;
    cycle_count = 0;
    tail_phase = 1'b0;
    calm_out = 1'b0;
    stall_left = 0;
    for (k = 0; k < 3; k++) begin
      box_row[k] = '0;
      box_shift[k] = '0;
    end
    box_size = '0;
    no_hit = '0;

    // phase 0 runs on reset registers (singular, so all miss); phase 1 on a unit box
    // of size 2 at the origin
    dir_rows = '{
      '{1'b0, 1'b1, {6{32'h0000_0000}}, 129'd0},
      '{1'b0, 1'b1, {6{32'h7fff_ffff}}, 129'd0},
      '{1'b0, 1'b1, {6{32'h8000_0000}}, 129'd0},
      '{1'b0, 1'b1, {32'hfffb_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0}, 129'd0},
      // straight along x from -5: enters at t=4, point (-1,0,0)
      '{1'b1, 1'b1, {32'hfffb_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0},
        {1'b1, 32'h0004_0000, 32'hffff_0000, 32'h0, 32'h0}},
      // still ray inside the box: entry unbounded, point is the origin
      '{1'b1, 1'b1, {6{32'h0}}, {1'b1, 32'h8000_0000, 96'd0}},
      // still ray outside the box
      '{1'b1, 1'b1, {32'h0005_0000, 32'h0, 32'h0, 96'd0}, 129'd0},
      // parallel to x but offset in y: misses
      '{1'b1, 1'b1, {32'hfffb_0000, 32'h0003_0000, 32'h0, 32'h0001_0000, 64'd0}, 129'd0},
      '{1'b1, 1'b0, {32'hfffb_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 64'd0}, 129'd0},
      '{1'b1, 1'b0, {32'h0005_0000, 32'h0, 32'h0, 32'hffff_0000, 64'd0}, 129'd0},
      '{1'b1, 1'b0, {96'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000}, 129'd0},
      '{1'b1, 1'b0, {32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h8000_0000, 64'd0}, 129'd0},
      '{1'b1, 1'b0, {32'hfffd_0000, 32'hfffd_0000, 32'hfffd_0000, {3{32'h0001_0000}}},
        129'd0},
      '{1'b1, 1'b0, {32'h8000_0000, 32'h0, 32'h0, 32'h0000_0001, 64'd0}, 129'd0},
      '{1'b1, 1'b0, {32'h0, 32'h0, 32'h7fff_ffff, 64'd0, 32'h8000_0001}, 129'd0},
      '{1'b1, 1'b0, {32'h0000_8000, 32'hffff_8000, 32'h0, 32'h0000_0001, 32'h7fff_ffff,
        32'h0}, 129'd0}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) drain();
      case (ph)
        0: ;
        1: load_box(48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000,
                    32'h0, 32'h0, 32'h0, 60'h00200_00200_00200);
        // extremes: strongest diagonal, translations at both ends, largest box
        2: load_box(48'h0000_0000_8000, 48'h0000_7fff_0000, 48'h7fff_0000_0000,
                    32'h8000_0000, 32'h7fff_ffff, 32'h0, 60'hfffff_fffff_fffff);
        // every register bit set: singular matrix
        3: load_box(48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff,
                    32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 60'hfffff_fffff_fffff);
        // smallest nonzero box on a unit frame
        4: load_box(48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000,
                    32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 60'h00001_00001_00001);
        default: load_random_box();
      endcase
      tail_phase = (ph == NUM_PHASES - 1);
      for (k = 0; k < NUM_DIRECT; k++)
        if (dir_rows[k].ph == ph[0] && ph <= 1) begin
          maybe_gap();
          send_ray(dir_rows[k].ray, dir_rows[k].typed, dir_rows[k].want);
        end
      n = (ph == 0) ? 20 : 140;
      for (k = 0; k < n; k++) begin
        maybe_gap();
        send_ray(rand_ray(), 1'b0, no_hit);
      end
    end

    in_valid <= 1'b0;
    wait_cycles = 0;
    while (hit_queue.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (hit_queue.size() != 0) begin
      $display("%0d results never arrived", hit_queue.size());
      fail_count++;
    end
    repeat (TOT_LAT + 10) @(posedge clk);

    $display("%0d rays over %0d box setups, %0d results checked, %0d hits",
             items_sent, NUM_PHASES, results_seen, hits_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule
